/* rtl/dual_pool_bitmap_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual-pool bitmap allocator
// Clocked property checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DUAL_POOL_BITMAP_ALLOCATOR_ASSERT_SVH
`define DUAL_POOL_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// check a property while out of reset
`define DPBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property at every edge, reset included
`define DPBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPBA_ASSERT(lbl, clk, rst, prop, msg)
`define DPBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/dpba_pkg.sv */
// ----------------------------------------------------------------------------
// Dual-pool bitmap allocator package
// Map geometry, request and status codes, controller states, bit search.
// ----------------------------------------------------------------------------
package dpba_pkg;

  localparam int MAP_BITS  = 65536;
  localparam int WORD_BITS = 64;   // power of two

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int POS_W     = ADDR_W + BIT_W;
  localparam int NUM_W     = ((POS_W > 16) ? POS_W : 16) + 1;

  localparam logic [16:0] NUM_SPAN = 17'h10000;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RESERVE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FREE  = 2'd3;

  localparam logic [1:0] CFG_ZONE_BASE   = 2'd0;
  localparam logic [1:0] CFG_ZONE_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_INODE_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_RMW,
    S_DONE
  } state_t;

  // index of the lowest set bit; zero when none is set
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/dual_pool_bitmap_allocator.sv */
// Free/reserve: the map word is read in S_CHECK and modified in S_RMW; the
// result waits in S_DONE until the output is free. Allocate: the scan reads
// one word per cycle from word 0 up to the first map word with a clear bit, or
// up to the last word when the pool is full. One item is in work at a time.
// Reset: both maps are swept to zero, one word of each per cycle, over all
// MAP_WORDS (1024) words; no item is taken during the sweep.
// ----------------------------------------------------------------------------
// Dual-pool bitmap allocator
// First-fit zone and inode allocator over two word-wide free bitmaps held in
// synchronous memories, with free and reserve by number.
// ----------------------------------------------------------------------------
`include "dual_pool_bitmap_allocator_assert.svh"

module dual_pool_bitmap_allocator import dpba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        pool,
  input  logic [15:0] number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] number_res,
  output logic [1:0]  status
);

  logic [WORD_BITS-1:0] zone_mem  [MAP_WORDS];
  logic [WORD_BITS-1:0] inode_mem [MAP_WORDS];

  state_t state, state_next;

  logic [15:0]          zone_base;
  logic [16:0]          zone_limit;
  logic [16:0]          inode_limit;

  logic [ADDR_W-1:0]    clr_addr;
  logic [ADDR_W-1:0]    scan_addr;
  logic                 chk_valid;
  logic [ADDR_W-1:0]    chk_addr;

  logic [1:0]           req_mode;
  logic                 req_pool;
  logic [15:0]          req_number;
  logic [ADDR_W-1:0]    tgt_addr;
  logic [BIT_W-1:0]     tgt_bit;

  logic [WORD_BITS-1:0] zone_rdata;
  logic [WORD_BITS-1:0] inode_rdata;

  logic [15:0]          res_num, res_num_next;
  logic [1:0]           res_status, res_status_next;
  logic                 wr_pend, wr_pend_next;
  logic [ADDR_W-1:0]    wr_addr, wr_addr_next;
  logic [WORD_BITS-1:0] wr_data, wr_data_next;
  logic                 res_load;

  logic [ADDR_W-1:0]    mem_raddr;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 zone_we;
  logic                 inode_we;
  logic                 out_free;
  logic                 out_load;
  logic                 in_accept;

  // request decode
  logic [15:0]          base_sel;
  logic [16:0]          lim_raw;
  logic [16:0]          lim_eff;
  logic                 num_ok;
  logic [15:0]          rel_pos;
  logic [NUM_W-1:0]     rel_ext;
  logic [NUM_W-1:0]     rel_word;
  logic                 pos_ok;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     free_idx;
  logic [POS_W-1:0]     scan_pos;
  logic [NUM_W-1:0]     scan_num;
  logic                 scan_fits;
  logic [WORD_BITS-1:0] tgt_mask;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_DONE) && out_free;

  assign base_sel = req_pool ? 16'd0 : zone_base;
  assign lim_raw  = req_pool ? inode_limit : zone_limit;
  assign lim_eff  = (lim_raw > NUM_SPAN) ? NUM_SPAN : lim_raw;

  assign num_ok   = ({1'b0, req_number} < lim_eff) && (req_number >= base_sel);
  assign rel_pos  = req_number - base_sel;
  assign rel_ext  = NUM_W'(rel_pos);
  assign rel_word = rel_ext >> BIT_W;
  assign pos_ok   = (rel_ext < NUM_W'(MAP_BITS)) && (rel_word < NUM_W'(MAP_WORDS));

  assign cur_word  = req_pool ? inode_rdata : zone_rdata;
  assign free_bits = ~cur_word;
  assign free_idx  = lowest_set(free_bits);
  assign scan_pos  = {chk_addr, free_idx};
  assign scan_num  = NUM_W'(base_sel) + NUM_W'(scan_pos);
  assign scan_fits = (NUM_W'(scan_pos) < NUM_W'(MAP_BITS)) && (scan_num < NUM_W'(lim_eff));
  assign tgt_mask  = WORD_BITS'(1) << tgt_bit;

  always_comb begin
    state_next      = state;
    in_stall        = 1'b1;
    mem_raddr       = '0;
    mem_waddr       = wr_addr;
    mem_wdata       = wr_data;
    zone_we         = 1'b0;
    inode_we        = 1'b0;
    res_load        = 1'b0;
    res_num_next    = '0;
    res_status_next = STAT_OK;
    wr_pend_next    = 1'b0;
    wr_addr_next    = tgt_addr;
    wr_data_next    = cur_word;
    unique case (state)
      S_CLEAR: begin
        mem_waddr = clr_addr;
        mem_wdata = '0;
        zone_we   = 1'b1;
        inode_we  = 1'b1;
        if (clr_addr == ADDR_W'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (mode == MODE_ALLOC) ? S_SCAN : S_CHECK;
        end
      end
      S_SCAN: begin
        mem_raddr = scan_addr;
        if (chk_valid) begin
          if (|free_bits) begin
            res_load = 1'b1;
            if (scan_fits) begin
              res_num_next    = scan_num[15:0];
              res_status_next = STAT_OK;
              wr_pend_next    = 1'b1;
              wr_addr_next    = chk_addr;
              wr_data_next    = cur_word | (WORD_BITS'(1) << free_idx);
            end else begin
              res_status_next = STAT_FULL;
            end
            state_next = S_DONE;
          end else if (chk_addr == ADDR_W'(MAP_WORDS - 1)) begin
            res_load        = 1'b1;
            res_status_next = STAT_FULL;
            state_next      = S_DONE;
          end
        end
      end
      S_CHECK: begin
        mem_raddr = rel_word[ADDR_W-1:0];
        case (req_mode) inside
          MODE_FREE, MODE_RESERVE: begin
            if (num_ok && pos_ok) begin
              state_next = S_RMW;
            end else begin
              res_load        = 1'b1;
              res_status_next = STAT_RANGE;
              state_next      = S_DONE;
            end
          end
          default: begin
            res_load        = 1'b1;
            res_status_next = STAT_RANGE;
            state_next      = S_DONE;
          end
        endcase
      end
      S_RMW: begin
        res_load   = 1'b1;
        state_next = S_DONE;
        if (req_mode == MODE_RESERVE) begin
          wr_pend_next = 1'b1;
          wr_data_next = cur_word | tgt_mask;
        end else if ((cur_word & tgt_mask) == '0) begin
          res_status_next = STAT_FREE;
        end else begin
          wr_pend_next = 1'b1;
          wr_data_next = cur_word & ~tgt_mask;
        end
      end
      S_DONE: begin
        if (out_free) begin
          zone_we    = wr_pend && !req_pool;
          inode_we   = wr_pend && req_pool;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_base   <= '0;
      zone_limit  <= NUM_SPAN;
      inode_limit <= NUM_SPAN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZONE_BASE:   zone_base   <= cfg_data[15:0];
        CFG_ZONE_LIMIT:  zone_limit  <= cfg_data;
        CFG_INODE_LIMIT: inode_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sweep and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      scan_addr <= '0;
      chk_valid <= 1'b0;
      chk_addr  <= '0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_SCAN) begin
        scan_addr <= scan_addr + 1'b1;
        chk_addr  <= scan_addr;
        chk_valid <= 1'b1;
      end else begin
        scan_addr <= '0;
        chk_valid <= 1'b0;
      end
    end
  end

  // request and pending result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_mode   <= mode;
      req_pool   <= pool;
      req_number <= number;
    end
    if (state == S_CHECK) begin
      tgt_addr <= rel_word[ADDR_W-1:0];
      tgt_bit  <= rel_pos[BIT_W-1:0];
    end
    if (res_load) begin
      res_num    <= res_num_next;
      res_status <= res_status_next;
      wr_pend    <= wr_pend_next;
      wr_addr    <= wr_addr_next;
      wr_data    <= wr_data_next;
    end
  end

  // bitmap memories
  always_ff @(posedge clk) begin
    if (zone_we) begin
      zone_mem[mem_waddr] <= mem_wdata;
    end
    if (inode_we) begin
      inode_mem[mem_waddr] <= mem_wdata;
    end
    zone_rdata  <= zone_mem[mem_raddr];
    inode_rdata <= inode_mem[mem_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      number_res <= res_num;
      status     <= res_status;
    end
  end

  `DPBA_ASSERT(a_accept_idle, clk, rst, (in_accept |-> state == S_IDLE), "item taken outside idle")
  `DPBA_ASSERT(a_dual_write_clear, clk, rst, ((zone_we && inode_we) |-> state == S_CLEAR), "both maps written outside sweep")
  `DPBA_ASSERT(a_done_to_idle, clk, rst, (out_load |=> (state == S_IDLE && out_valid)), "result load did not return to idle")
  `DPBA_ASSERT(a_num_zero_on_fail, clk, rst, ((out_valid && status != STAT_OK) |-> number_res == 16'd0), "nonzero number with failing status")
  `DPBA_ASSERT_ALWAYS(a_reset_sweep, clk, (rst |=> (state == S_CLEAR && !out_valid)), "reset did not start the sweep")

endmodule
